// ----- hdl/cdfs_pkg.sv -----
// Package: types, constants and lookup functions for the clock display frame sender.
package cdfs_pkg;

	// Bus symbol kinds
	typedef enum logic [1:0] {
		SYM_START = 2'd0,
		SYM_DATA  = 2'd1,
		SYM_STOP  = 2'd2
	} sym_kind_t;

	// Display commands
	localparam logic [7:0] CMD_FIXED_MODE = 8'h44;
	localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
	localparam logic [7:0] CMD_CTRL_BASE  = 8'h88;

	localparam int unsigned FRAME_LEN = 22;
	localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

	// Symbol index of the first start of the control command
	localparam logic [CNT_W-1:0] CNT_CTRL = CNT_W'(FRAME_LEN - 3);
	localparam logic [CNT_W-1:0] CNT_DIGITS = CNT_W'(3);

	// Configuration register indexes (word addresses)
	localparam logic REG_BRIGHTNESS = 1'b0;

	// Four segment bytes of one frame, hours tens first
	typedef struct packed {
		logic [3:0][7:0] seg;
	} cdfs_slot_t;

	// One output symbol
	typedef struct packed {
		sym_kind_t   kind;
		logic [7:0]  value;
		logic        last;
	} cdfs_sym_t;

	// Seven-segment patterns for hex digits
	function automatic logic [6:0] seg_lut(input logic [3:0] d);
		logic [6:0] r;
		unique case (d)
			4'h0: r = 7'h3f;
			4'h1: r = 7'h06;
			4'h2: r = 7'h5b;
			4'h3: r = 7'h4f;
			4'h4: r = 7'h66;
			4'h5: r = 7'h6d;
			4'h6: r = 7'h7d;
			4'h7: r = 7'h07;
			4'h8: r = 7'h7f;
			4'h9: r = 7'h6f;
			4'ha: r = 7'h77;
			4'hb: r = 7'h7c;
			4'hc: r = 7'h39;
			4'hd: r = 7'h5e;
			4'he: r = 7'h79;
			default: r = 7'h71;
		endcase
		return r;
	endfunction

	// Tens digit of a 7-bit value: v*205 >> 11 is exact for 0..127
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	// Units digit: value minus ten times the tens digit
	function automatic logic [3:0] units_of(input logic [6:0] v, input logic [3:0] t);
		logic [6:0] diff;
		diff = v - (7'(t) * 7'd10);
		return diff[3:0];
	endfunction

	// Symbol at a given frame position
	function automatic cdfs_sym_t frame_sym(input logic [CNT_W-1:0] cnt,
	                                        input cdfs_slot_t      slot,
	                                        input logic [2:0]      bright);
		cdfs_sym_t        s;
		logic [CNT_W-1:0] off;
		logic [1:0]       pos;
		off = cnt - CNT_DIGITS;
		pos = off[3:2];
		s.kind  = SYM_START;
		s.value = 8'h00;
		s.last  = (cnt == CNT_LAST);
		if (cnt < CNT_DIGITS) begin
			// mode command
			unique case (cnt[1:0])
				2'd0: s.kind = SYM_START;
				2'd1: begin
					s.kind  = SYM_DATA;
					s.value = CMD_FIXED_MODE;
				end
				default: s.kind = SYM_STOP;
			endcase
		end else if (cnt < CNT_CTRL) begin
			// address + segment byte per digit
			unique case (off[1:0])
				2'd0: s.kind = SYM_START;
				2'd1: begin
					s.kind  = SYM_DATA;
					s.value = CMD_ADDR_BASE | {6'd0, pos};
				end
				2'd2: begin
					s.kind  = SYM_DATA;
					s.value = slot.seg[pos];
				end
				default: s.kind = SYM_STOP;
			endcase
		end else begin
			// display control
			unique case (5'(cnt - CNT_CTRL))
				5'd0: s.kind = SYM_START;
				5'd1: begin
					s.kind  = SYM_DATA;
					s.value = CMD_CTRL_BASE | {5'd0, bright};
				end
				default: s.kind = SYM_STOP;
			endcase
		end
		return s;
	endfunction

endpackage

// ----- hdl/cdfs_encode.sv -----
// Input stage: digit split, segment encoding and dot flag toggle.
module cdfs_encode import cdfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [6:0] hours,
	input  logic [6:0] minutes,
	output logic       slot_valid,
	input  logic       slot_take,
	output cdfs_slot_t slot
);

	logic       valid_s1;
	cdfs_slot_t slot_s1;
	logic       dot_q;
	logic       accept;
	logic       dot_next;
	logic [3:0] h_t, h_u, m_t, m_u;

	// slot frees up in the same cycle the sequencer takes it
	assign in_ready = !valid_s1 || slot_take;
	assign accept   = in_valid && in_ready;
	assign dot_next = ~dot_q;

	assign h_t = tens_of(hours);
	assign h_u = units_of(hours, h_t);
	assign m_t = tens_of(minutes);
	assign m_u = units_of(minutes, m_t);

	// control: slot valid and dot flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dot_q    <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			dot_q    <= dot_next;
		end else if (slot_take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: segment bytes with the dot bit
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1.seg[0] <= {dot_next, seg_lut(h_t)};
			slot_s1.seg[1] <= {dot_next, seg_lut(h_u)};
			slot_s1.seg[2] <= {dot_next, seg_lut(m_t)};
			slot_s1.seg[3] <= {dot_next, seg_lut(m_u)};
		end
	end

	assign slot_valid = valid_s1;
	assign slot       = slot_s1;

endmodule

// ----- hdl/cdfs_seq.sv -----
// Frame sequencer: walks the 22 symbols of a frame into the output register.
module cdfs_seq import cdfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       slot_valid,
	output logic       slot_take,
	input  cdfs_slot_t slot,
	input  logic [2:0] brightness,
	output logic       out_valid,
	input  logic       out_ready,
	output cdfs_sym_t  out_sym
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	cdfs_slot_t       frame_q;
	logic             valid_q;
	cdfs_sym_t        sym_q;
	logic             advance;
	logic             done;

	assign advance   = !valid_q || out_ready;
	assign done      = !busy_q || (cnt_q == CNT_LAST);
	assign slot_take = advance && done && slot_valid;

	// control: frame position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= busy_q;
			if (slot_take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload: frame bytes and output symbol
	always_ff @(posedge clk) begin
		if (slot_take)
			frame_q <= slot;
		if (advance)
			sym_q <= frame_sym(cnt_q, frame_q, brightness);
	end

	assign out_valid = valid_q;
	assign out_sym   = sym_q;

endmodule

// ----- hdl/clock_display_frame_sender_top.sv -----
// Top level of the clock display frame sender.
//
// Slave stream: one word per time update, hours in tdata[6:0], minutes in
// tdata[13:7]. Each word toggles the colon/dot flag and produces a 22-word
// frame on the master stream: start, 0x44, stop, then per digit start,
// 0xC0|pos, segment byte, stop, then start, 0x88|brightness, stop. tlast
// marks the final stop.
// The input word passes the encode slot register and the sequencer's frame
// register and counter before its first symbol reaches the output register.
// The sequencer emits one symbol of one frame at a time, one symbol per cycle
// while the master side is ready. One further word is buffered in the encode
// stage, so input is taken while a frame is still being sent.
// A stalled master side holds the current symbol and freezes the
// sequencer; the slave side then backs up after one buffered word.
// Reset clears the dot flag (off), all valid flags and sets brightness to 7.
// APB: brightness at addresses 0-3 (paddr[2] low), low three bits; writes to 4-7 ignored.
module clock_display_frame_sender_top import cdfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] hours, [13:7] minutes, [15:14] zero
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] symbol_kind, [9:2] byte_value, [15:10] zero
	output logic        m_tlast,   // frame_end
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       bright_sel;
	logic [2:0] bright_q;
	logic       slot_valid;
	logic       slot_take;
	cdfs_slot_t slot;
	cdfs_sym_t  sym;

	assign pready = 1'b1;
	assign bright_sel = (paddr[2] == REG_BRIGHTNESS);

	// brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= 3'd7;
		end else if (psel && penable && pwrite && pready && bright_sel) begin
			bright_q <= pwdata[2:0];
		end
	end

	assign prdata = bright_sel ? {29'd0, bright_q} : 32'd0;

	cdfs_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.hours      (s_tdata[6:0]),
		.minutes    (s_tdata[13:7]),
		.slot_valid (slot_valid),
		.slot_take  (slot_take),
		.slot       (slot)
	);

	cdfs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_valid (slot_valid),
		.slot_take  (slot_take),
		.slot       (slot),
		.brightness (bright_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sym    (sym)
	);

	assign m_tdata = {6'd0, sym.value, sym.kind};
	assign m_tlast = sym.last;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the clock display frame sender: stream stimulus, APB setup, frame checks.
`timescale 1ns / 1ps

module testbench;
	import cdfs_pkg::*;

	localparam int          CLK_PERIOD   = 12;
	localparam int          CYCLE_LIMIT  = 800000;
	localparam int          DRAIN_CYCLES = 30;
	localparam logic [2:0]  ADDR_BRIGHT  = {REG_BRIGHTNESS, 2'b00};
	localparam logic [2:0]  ADDR_UNUSED  = 3'd4;   // one past the last register
	localparam logic [7:0]  DOT_MASK     = 8'h80;
	localparam logic [7:0]  DIGIT_SEGS [0:15] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
		8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state and the symbols still owed by the block
	logic       dot_model    = 1'b0;
	logic [2:0] bright_model = 3'd7;
	cdfs_sym_t  pending_syms [$];

	int unsigned mismatches  = 0;
	int unsigned words_sent  = 0;
	int unsigned syms_seen   = 0;
	int unsigned cycle_count = 0;
	int unsigned s_gap_max   = 12;
	int unsigned m_gap_max   = 12;
	logic [7:0]  bright_seen = '0;

	clock_display_frame_sender_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d symbols outstanding", $time, pending_syms.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Segment byte of one digit, dot bit added while the colon flag is on
	function automatic logic [7:0] digit_pattern(input int unsigned d, input logic dot);
		return DIGIT_SEGS[d & 15] | (dot ? DOT_MASK : 8'h00);
	endfunction

	function automatic void push_sym(input sym_kind_t kind, input logic [7:0] value,
	                                 input logic last);
		cdfs_sym_t s;
		s.kind  = kind;
		s.value = value;
		s.last  = last;
		pending_syms.push_back(s);
	endfunction

	// Full 22-symbol frame for one time update
	function automatic void predict_frame(input logic [6:0] hrs, input logic [6:0] mins);
		logic [7:0] segs [4];
		dot_model = ~dot_model;
		segs[0] = digit_pattern(hrs / 10, dot_model);
		segs[1] = digit_pattern(hrs % 10, dot_model);
		segs[2] = digit_pattern(mins / 10, dot_model);
		segs[3] = digit_pattern(mins % 10, dot_model);
		push_sym(SYM_START, 8'h00, 1'b0);
		push_sym(SYM_DATA, CMD_FIXED_MODE, 1'b0);
		push_sym(SYM_STOP, 8'h00, 1'b0);
		for (int p = 0; p < 4; p++) begin
			push_sym(SYM_START, 8'h00, 1'b0);
			push_sym(SYM_DATA, CMD_ADDR_BASE | 8'(p), 1'b0);
			push_sym(SYM_DATA, segs[p], 1'b0);
			push_sym(SYM_STOP, 8'h00, 1'b0);
		end
		push_sym(SYM_START, 8'h00, 1'b0);
		push_sym(SYM_DATA, CMD_CTRL_BASE | {5'd0, bright_model}, 1'b0);
		push_sym(SYM_STOP, 8'h00, 1'b1);
	endfunction

	// Send one time update word after a random gap
	task automatic send_time(input logic [6:0] hrs, input logic [6:0] mins);
		int unsigned gap;
		gap = $urandom_range(0, s_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, mins, hrs};
		do @(posedge clk); while (!s_tready);
		predict_frame(hrs, mins);
		words_sent++;
	endtask

	// Drop valid and wait until every owed symbol has come out
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (pending_syms.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_BRIGHT) begin
			bright_model = data[2:0];
			bright_seen[data[2:0]] = 1'b1;
		end
	endtask

	// Read brightness back and compare with the model
	task automatic check_brightness();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_BRIGHT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(bright_model)) begin
			mismatches++;
			$display("%0t: brightness read expected %0h actual %0h", $time,
			         32'(bright_model), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly clock-like values, some over-range ones
	function automatic logic [6:0] rand_field();
		if ($urandom_range(0, 9) < 8)
			return 7'($urandom_range(0, 99));
		return 7'($urandom_range(0, 127));
	endfunction

	// Receiver: random stall drawn for every word
	initial begin
		int unsigned stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, m_gap_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each accepted symbol with the oldest expectation
	always @(posedge clk) begin : check_symbols
		cdfs_sym_t want;
		if (arst_n && m_tvalid && m_tready) begin
			syms_seen++;
			if (pending_syms.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected symbol, expected none actual kind %0d byte %0h last %0b",
				         $time, m_tdata[1:0], m_tdata[9:2], m_tlast);
			end else begin
				want = pending_syms.pop_front();
				if (m_tdata[1:0] !== want.kind) begin
					mismatches++;
					$display("%0t: symbol_kind expected %0d actual %0d", $time,
					         want.kind, m_tdata[1:0]);
				end
				if (m_tdata[9:2] !== want.value) begin
					mismatches++;
					$display("%0t: byte_value expected %0h actual %0h", $time,
					         want.value, m_tdata[9:2]);
				end
				if (m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: frame_end expected %0b actual %0b", $time,
					         want.last, m_tlast);
				end
			end
		end
	end

	// Reset value of brightness and the digit extremes
	task automatic test_defaults();
		check_brightness();
		bright_seen[bright_model] = 1'b1;
		send_time(7'd0, 7'd0);
		send_time(7'd99, 7'd99);
		send_time(7'd88, 7'd88);
		send_time(7'd12, 7'd34);
		send_time(7'd23, 7'd59);
		drain_stream();
	endtask

	// Values above 99: tens digits 10, 11 and 12
	task automatic test_over_range();
		send_time(7'd100, 7'd100);
		send_time(7'd109, 7'd119);
		send_time(7'd127, 7'd127);
		send_time(7'd120, 7'd5);
		send_time(7'd0, 7'd127);
		send_time(7'd101, 7'd110);
		drain_stream();
	endtask

	// Brightness extremes, and a write past the register list
	task automatic test_brightness();
		logic [2:0] levels [3] = '{3'd0, 3'd7, 3'd3};
		foreach (levels[i]) begin
			apb_write(ADDR_BRIGHT, {29'h1234567, levels[i]});
			check_brightness();
			send_time(7'd45, 7'd67);
			send_time(7'd9, 7'd10);
			drain_stream();
		end
		apb_write(ADDR_UNUSED, 32'hFFFF_FFF8);
		check_brightness();
		send_time(7'd19, 7'd59);
		drain_stream();
	endtask

	// Random updates in phases with different brightness and idling
	task automatic test_random();
		int unsigned gap_modes [4] = '{0, 12, 3, 12};
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(ADDR_BRIGHT, 32'($urandom_range(0, 7)));
			s_gap_max = gap_modes[ph % 4];
			m_gap_max = gap_modes[(ph + 1) % 4];
			for (int n = 0; n < 60; n++)
				send_time(rand_field(), rand_field());
			drain_stream();
		end
		s_gap_max = 12;
		m_gap_max = 12;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_over_range();
		test_brightness();
		test_random();
		while (pending_syms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d time updates (incl. tens digits 10-12), checked %0d bus symbols,",
		         words_sent, syms_seen);
		$display("brightness levels used: %08b, random stalls on both streams", bright_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
